// File: hw/rtl/bsmm_pkg.sv
// Shared types and constants for the bank-switched memory mapper.
package bsmm_pkg;

    localparam int ROM_SLOT_COUNT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [2:0] {
        OP_BANK_MODE  = 3'd0,
        OP_SELECT_ROM = 3'd1,
        OP_ROM_ENABLE = 3'd2,
        OP_READ       = 3'd3,
        OP_WRITE      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_RAM   = 3'd0,
        KIND_LOWER = 3'd1,
        KIND_SLOT  = 3'd2,
        KIND_CART  = 3'd3,
        KIND_ZERO  = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BANKED_RAM_MODEL  = 3'd0,
        REG_EXPANSION_FITTED  = 3'd1,
        REG_CARTRIDGE_MODE    = 3'd2,
        REG_CARTRIDGE_LOADED  = 3'd3,
        REG_SLOT_PRESENT_MASK = 3'd4
    } reg_index_t;

    localparam logic [7:0]  CART_BANK_FIRST = 8'h80;
    localparam logic [15:0] SLOT_MASK_RESET = 16'h0081;

    typedef struct packed {
        kind_t       target_kind;
        logic [5:0]  page_index;
        logic [13:0] page_offset;
    } result_t;

endpackage

// File: hw/rtl/bank_switched_memory_mapper.sv
// Top level of the bank-switched memory mapper: state, decode and output buffering.
//
// Takes one word per clock while s_axis_tready is high. Control words (bank mode,
// ROM select, ROM enables) update the mapping state and give no result; each read
// or write access gives one result word in the cycle after it is accepted when the
// output register is free or drains in that cycle, else it waits in the skid entry.
// The map is decoded in the accept cycle from the current state, so a control word
// affects the very next access. Results go to an output register backed by one skid
// entry, so s_axis_tready is low in every cycle in which the skid entry holds a word.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must only be issued while no access result is pending.
module bank_switched_memory_mapper #(
    parameter int ROM_SLOT_COUNT = bsmm_pkg::ROM_SLOT_COUNT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // cpu_address, control_value
    input  logic [2:0]                       s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // page_index, page_offset, pad
    output logic [2:0]                       m_axis_tuser,  // target_kind
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bsmm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic        banked_ram_model_reg;
    logic        expansion_fitted_reg;
    logic        cartridge_mode_reg;
    logic        cartridge_loaded_reg;
    logic [15:0] slot_present_mask_reg;

    logic [5:0]  bank_mode_reg;
    logic [7:0]  upper_rom_number_reg;
    logic        lower_rom_on_reg;
    logic        upper_rom_on_reg;

    logic               out_valid_reg;
    bsmm_pkg::result_t  out_data_reg;
    logic               skid_valid_reg;
    bsmm_pkg::result_t  skid_data_reg;

    bsmm_pkg::op_t      in_op;
    logic [15:0]        in_addr;
    logic [7:0]         in_cv;
    logic [1:0]         quarter;
    logic               in_accept;
    logic               is_access;
    logic               out_pop;
    logic [2:0]         blk;
    logic [5:0]         ram_idx;
    bsmm_pkg::result_t  result;

    assign in_op   = bsmm_pkg::op_t'(s_axis_tuser);
    assign in_addr = s_axis_tdata[15:0];
    assign in_cv   = s_axis_tdata[23:16];
    assign quarter = in_addr[15:14];

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_access     = (in_op == bsmm_pkg::OP_READ) || (in_op == bsmm_pkg::OP_WRITE);
    assign out_pop       = out_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    // RAM page: expansion page i of block b is 4*b + 4 + i
    always_comb begin
        blk = expansion_fitted_reg ? bank_mode_reg[5:3] : 3'd0;
        ram_idx = {4'd0, quarter};
        if (banked_ram_model_reg || expansion_fitted_reg) begin
            case (bank_mode_reg[2:0])
                3'd0: ram_idx = {4'd0, quarter};
                3'd1: begin
                    if (quarter == 2'd3) begin
                        ram_idx = {1'b0, blk, 2'd3} + 6'd4;
                    end
                end
                3'd2: ram_idx = {1'b0, blk, quarter} + 6'd4;
                3'd3: begin
                    if (quarter == 2'd1) begin
                        ram_idx = 6'd3;
                    end else if (quarter == 2'd3) begin
                        ram_idx = {1'b0, blk, 2'd3} + 6'd4;
                    end
                end
                default: begin
                    if (quarter == 2'd1) begin
                        ram_idx = {1'b0, blk, bank_mode_reg[1:0]} + 6'd4;
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.target_kind = bsmm_pkg::KIND_RAM;
        result.page_index  = ram_idx;
        result.page_offset = in_addr[13:0];
        if (in_op == bsmm_pkg::OP_READ) begin
            if (quarter == 2'd0 && lower_rom_on_reg) begin
                result.target_kind = (cartridge_mode_reg && cartridge_loaded_reg)
                                   ? bsmm_pkg::KIND_CART : bsmm_pkg::KIND_LOWER;
                result.page_index  = 6'd0;
            end else if (quarter == 2'd3 && upper_rom_on_reg) begin
                result.target_kind = bsmm_pkg::KIND_ZERO;
                result.page_index  = 6'd0;
                if (cartridge_mode_reg) begin
                    if (cartridge_loaded_reg) begin
                        if (upper_rom_number_reg[7:5] == bsmm_pkg::CART_BANK_FIRST[7:5]) begin
                            result.target_kind = bsmm_pkg::KIND_CART;
                            result.page_index  = {1'b0, upper_rom_number_reg[4:0]};
                        end else if (upper_rom_number_reg == 8'd0) begin
                            result.target_kind = bsmm_pkg::KIND_CART;
                            result.page_index  = 6'd1;
                        end else if (upper_rom_number_reg == 8'd7) begin
                            result.target_kind = bsmm_pkg::KIND_CART;
                            result.page_index  = 6'd2;
                        end else if (upper_rom_number_reg[7:4] == 4'd0) begin
                            result.target_kind = bsmm_pkg::KIND_CART;
                            result.page_index  = {2'd0, upper_rom_number_reg[3:0]};
                        end
                    end
                end else begin
                    if (upper_rom_number_reg < 8'(ROM_SLOT_COUNT)
                        && upper_rom_number_reg[7:4] == 4'd0
                        && slot_present_mask_reg[upper_rom_number_reg[3:0]]) begin
                        result.target_kind = bsmm_pkg::KIND_SLOT;
                        result.page_index  = {2'd0, upper_rom_number_reg[3:0]};
                    end else if (slot_present_mask_reg[0]) begin
                        result.target_kind = bsmm_pkg::KIND_SLOT;
                        result.page_index  = 6'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            banked_ram_model_reg  <= 1'b1;
            expansion_fitted_reg  <= 1'b0;
            cartridge_mode_reg    <= 1'b0;
            cartridge_loaded_reg  <= 1'b0;
            slot_present_mask_reg <= bsmm_pkg::SLOT_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bsmm_pkg::REG_BANKED_RAM_MODEL:  banked_ram_model_reg  <= cfg_data[0];
                bsmm_pkg::REG_EXPANSION_FITTED:  expansion_fitted_reg  <= cfg_data[0];
                bsmm_pkg::REG_CARTRIDGE_MODE:    cartridge_mode_reg    <= cfg_data[0];
                bsmm_pkg::REG_CARTRIDGE_LOADED:  cartridge_loaded_reg  <= cfg_data[0];
                bsmm_pkg::REG_SLOT_PRESENT_MASK: slot_present_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_mode_reg        <= 6'd0;
            upper_rom_number_reg <= 8'd0;
            lower_rom_on_reg     <= 1'b1;
            upper_rom_on_reg     <= 1'b1;
        end else if (in_accept) begin
            case (in_op)
                bsmm_pkg::OP_BANK_MODE:  bank_mode_reg        <= in_cv[5:0];
                bsmm_pkg::OP_SELECT_ROM: upper_rom_number_reg <= in_cv;
                bsmm_pkg::OP_ROM_ENABLE: begin
                    lower_rom_on_reg <= in_cv[0];
                    upper_rom_on_reg <= in_cv[1];
                end
                default: ;
            endcase
        end
    end

    // Output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_accept && is_access) begin
            if (out_valid_reg && !m_axis_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_accept && is_access) begin
            if (out_valid_reg && !m_axis_tready) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.target_kind;
    assign m_axis_tdata  = {4'd0, out_data_reg.page_offset, out_data_reg.page_index};

endmodule

// File: hw/rtl/bsmm_checker.sv
// Port-level checks for the bank-switched memory mapper, bound to the top level.
module bsmm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= 3'(bsmm_pkg::KIND_ZERO))
        else $error("target kind out of range");

    a_fixed_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == 3'(bsmm_pkg::KIND_LOWER)
                          || m_axis_tuser == 3'(bsmm_pkg::KIND_ZERO))
            |-> m_axis_tdata[5:0] == 6'd0)
        else $error("lower ROM or zero page with nonzero index");

    a_ram_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == 3'(bsmm_pkg::KIND_RAM)
            |-> m_axis_tdata[5:0] <= 6'd35)
        else $error("RAM page out of range");

    // access into an empty output shows up next cycle with its offset
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
            && (s_axis_tuser == 3'(bsmm_pkg::OP_READ)
                || s_axis_tuser == 3'(bsmm_pkg::OP_WRITE))
            |=> m_axis_tvalid && m_axis_tdata[19:6] == $past(s_axis_tdata[13:0]))
        else $error("access result missing or wrong offset");

endmodule

bind bank_switched_memory_mapper bsmm_checker u_bsmm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/bank_switched_memory_mapper_tb.sv
// Self-checking testbench for the bank-switched memory mapper: directed and random traffic.
module bank_switched_memory_mapper_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [bsmm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bsmm_pkg::CFG_DATA_W-1:0]  cfg_data;

    // mapper registers and state as predicted
    logic        banked_ram;
    logic        expansion_on;
    logic        cart_mode;
    logic        cart_loaded;
    logic [15:0] slot_mask;
    logic [5:0]  bank_mode_q;
    logic [7:0]  rom_number_q;
    logic        lower_on_q;
    logic        upper_on_q;

    bsmm_pkg::result_t expected_targets[$];
    int          error_count;
    int          cycle_count;
    bit          src_gaps_on;
    bit          sink_gaps_on;
    bit          hold_request;

    bank_switched_memory_mapper u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // RAM page seen in a quarter under the current bank mode
    function automatic logic [5:0] ram_page_of(input logic [1:0] quarter);
        int blk;
        int base;
        logic [2:0] layout;
        if (!banked_ram && !expansion_on) return 6'(quarter);
        blk = expansion_on ? int'(bank_mode_q[5:3]) : 0;
        base = (blk == 0) ? 4 : 8 + (blk - 1) * 4;
        layout = bank_mode_q[2:0];
        case (layout)
            3'd0: return 6'(quarter);
            3'd1: return (quarter == 2'd3) ? 6'(base + 3) : 6'(quarter);
            3'd2: return 6'(base + int'(quarter));
            3'd3: begin
                if (quarter == 2'd1) return 6'd3;
                if (quarter == 2'd3) return 6'(base + 3);
                return 6'(quarter);
            end
            default: return (quarter == 2'd1) ? 6'(base + int'(layout[1:0])) : 6'(quarter);
        endcase
    endfunction

    function automatic bsmm_pkg::result_t upper_rom_target();
        bsmm_pkg::result_t t;
        logic [7:0] n;
        n = rom_number_q;
        t.target_kind = bsmm_pkg::KIND_ZERO;
        t.page_index = '0;
        t.page_offset = '0;
        if (cart_mode) begin
            if (cart_loaded) begin
                if (n >= bsmm_pkg::CART_BANK_FIRST && n <= 8'h9F) begin
                    t.target_kind = bsmm_pkg::KIND_CART;
                    t.page_index = 6'(n - bsmm_pkg::CART_BANK_FIRST);
                end else if (n == 8'd0) begin
                    t.target_kind = bsmm_pkg::KIND_CART;
                    t.page_index = 6'd1;
                end else if (n == 8'd7) begin
                    t.target_kind = bsmm_pkg::KIND_CART;
                    t.page_index = 6'd2;
                end else if (n < 8'd16) begin
                    t.target_kind = bsmm_pkg::KIND_CART;
                    t.page_index = n[5:0];
                end
            end
        end else if (n < bsmm_pkg::ROM_SLOT_COUNT && n < 16 && slot_mask[n[3:0]]) begin
            t.target_kind = bsmm_pkg::KIND_SLOT;
            t.page_index = n[5:0];
        end else if (slot_mask[0]) begin
            t.target_kind = bsmm_pkg::KIND_SLOT;
            t.page_index = 6'd0;
        end
        return t;
    endfunction

    // updates the predicted state; returns 1 with the mapped target for accesses
    function automatic bit map_access(input logic [2:0] op, input logic [15:0] addr,
                                      input logic [7:0] cv,
                                      output bsmm_pkg::result_t target);
        logic [1:0] quarter;
        quarter = addr[15:14];
        target.target_kind = bsmm_pkg::KIND_RAM;
        target.page_index = ram_page_of(quarter);
        target.page_offset = addr[13:0];
        case (op)
            bsmm_pkg::OP_BANK_MODE: begin
                bank_mode_q = cv[5:0];
                return 1'b0;
            end
            bsmm_pkg::OP_SELECT_ROM: begin
                rom_number_q = cv;
                return 1'b0;
            end
            bsmm_pkg::OP_ROM_ENABLE: begin
                lower_on_q = cv[0];
                upper_on_q = cv[1];
                return 1'b0;
            end
            bsmm_pkg::OP_READ: begin
                if (quarter == 2'd0 && lower_on_q) begin
                    target.target_kind = (cart_mode && cart_loaded)
                                       ? bsmm_pkg::KIND_CART : bsmm_pkg::KIND_LOWER;
                    target.page_index = '0;
                end else if (quarter == 2'd3 && upper_on_q) begin
                    target.target_kind = upper_rom_target().target_kind;
                    target.page_index = upper_rom_target().page_index;
                end
                return 1'b1;
            end
            bsmm_pkg::OP_WRITE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        bsmm_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_targets.size() == 0) begin
                $display("%0t: unexpected result word, tuser %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_targets.pop_front();
                if (m_axis_tuser !== want.target_kind) begin
                    $display("%0t: target_kind expected %0d actual %0d",
                             $time, want.target_kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[5:0] !== want.page_index) begin
                    $display("%0t: page_index expected %0d actual %0d",
                             $time, want.page_index, m_axis_tdata[5:0]);
                    error_count++;
                end
                if (m_axis_tdata[19:6] !== want.page_offset) begin
                    $display("%0t: page_offset expected %h actual %h",
                             $time, want.page_offset, m_axis_tdata[19:6]);
                    error_count++;
                end
                if (m_axis_tdata[23:20] !== 4'd0) begin
                    $display("%0t: tdata pad expected 0 actual %h", $time, m_axis_tdata[23:20]);
                    error_count++;
                end
            end
        end
    end

    // result receiver, with random stalls and a long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = 300;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
                else if (sink_gaps_on) stall_left = pick_gap();
            end
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [15:0] addr,
                             input logic [7:0] cv);
        int gap;
        bsmm_pkg::result_t target;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cv, addr};
        s_axis_tuser <= op;
        do @(posedge aclk); while (!s_axis_tready);
        if (map_access(op, addr, cv, target)) expected_targets.push_back(target);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_targets.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input bsmm_pkg::reg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bsmm_pkg::REG_BANKED_RAM_MODEL:  banked_ram = value[0];
            bsmm_pkg::REG_EXPANSION_FITTED:  expansion_on = value[0];
            bsmm_pkg::REG_CARTRIDGE_MODE:    cart_mode = value[0];
            bsmm_pkg::REG_CARTRIDGE_LOADED:  cart_loaded = value[0];
            bsmm_pkg::REG_SLOT_PRESENT_MASK: slot_mask = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input bit banked, input bit expansion, input bit cmode,
                                 input bit loaded, input logic [15:0] mask);
        wait_idle();
        // upper data bits are don't-care for the flag registers
        write_register(bsmm_pkg::REG_BANKED_RAM_MODEL, {15'($urandom), banked});
        write_register(bsmm_pkg::REG_EXPANSION_FITTED, {15'($urandom), expansion});
        write_register(bsmm_pkg::REG_CARTRIDGE_MODE, {15'($urandom), cmode});
        write_register(bsmm_pkg::REG_CARTRIDGE_LOADED, {15'($urandom), loaded});
        write_register(bsmm_pkg::REG_SLOT_PRESENT_MASK, mask);
    endtask

    function automatic logic [15:0] random_address();
        if ($urandom_range(0, 4) == 0)
            return {2'($urandom), ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'h0000};
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] random_rom_number();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd7;
            2: return bsmm_pkg::CART_BANK_FIRST + 8'($urandom_range(0, 31));
            3: return 8'($urandom_range(0, 15));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_words(input int count);
        int r;
        logic [2:0] op;
        logic [7:0] cv;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                sink_gaps_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            cv = 8'($urandom);
            if (r < 40) op = bsmm_pkg::OP_READ;
            else if (r < 60) op = bsmm_pkg::OP_WRITE;
            else if (r < 72) op = bsmm_pkg::OP_BANK_MODE;
            else if (r < 84) begin
                op = bsmm_pkg::OP_SELECT_ROM;
                cv = random_rom_number();
            end else if (r < 94) op = bsmm_pkg::OP_ROM_ENABLE;
            else op = bsmm_pkg::OP_WRITE + 3'($urandom_range(1, 3));
            send_word(op, random_address(), cv);
        end
    endtask

    task automatic test_reset_map();
        for (int q = 0; q < 4; q++) begin
            send_word(bsmm_pkg::OP_READ, {2'(q), 14'h0000}, 8'h00);
            send_word(bsmm_pkg::OP_READ, {2'(q), 14'h3FFF}, 8'hFF);
        end
        send_word(bsmm_pkg::OP_WRITE, 16'hFFFF, 8'h00);
    endtask

    task automatic test_control_words();
        send_word(bsmm_pkg::OP_BANK_MODE, 16'h0000, 8'hFF);
        send_word(bsmm_pkg::OP_READ, 16'h4000, 8'h00);
        send_word(bsmm_pkg::OP_WRITE, 16'h0000, 8'h00);
        send_word(bsmm_pkg::OP_BANK_MODE, 16'hFFFF, 8'h02);
        send_word(bsmm_pkg::OP_WRITE, 16'hC123, 8'h00);
        send_word(bsmm_pkg::OP_ROM_ENABLE, 16'h0000, 8'hFC);
        send_word(bsmm_pkg::OP_READ, 16'h0000, 8'h00);
        send_word(bsmm_pkg::OP_READ, 16'hFFFF, 8'h00);
        send_word(bsmm_pkg::OP_ROM_ENABLE, 16'h0000, 8'h03);
        send_word(bsmm_pkg::OP_SELECT_ROM, 16'h0000, 8'h07);
        send_word(bsmm_pkg::OP_READ, 16'hC000, 8'h00);
        send_word(bsmm_pkg::OP_SELECT_ROM, 16'h0000, 8'h9F);
        send_word(bsmm_pkg::OP_READ, 16'hC000, 8'h00);
        send_word(bsmm_pkg::OP_WRITE + 3'd1, 16'hFFFF, 8'hFF);
        send_word(bsmm_pkg::OP_WRITE + 3'd3, 16'h0000, 8'h00);
        send_word(bsmm_pkg::OP_READ, 16'h8000, 8'h00);
    endtask

    task automatic test_config_sweep();
        apply_setting(1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        random_words(250);
        apply_setting(1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF);
        random_words(250);
        apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 16'($urandom));
        random_words(250);
        apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 16'($urandom));
        random_words(200);
        apply_setting(1'b1, 1'b0, 1'b1, 1'b1, 16'h0001);
        random_words(250);
        apply_setting(1'b1, 1'b0, 1'b0, 1'b0, bsmm_pkg::SLOT_MASK_RESET);
        random_words(250);
        apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFE);
        random_words(250);
    endtask

    // output held off long enough for the skid buffer to fill and stall the input
    task automatic test_output_stall();
        src_gaps_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(bsmm_pkg::OP_READ, 16'($urandom), 8'($urandom));
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        hold_request = 1'b0;
        banked_ram = 1'b1;
        expansion_on = 1'b0;
        cart_mode = 1'b0;
        cart_loaded = 1'b0;
        slot_mask = bsmm_pkg::SLOT_MASK_RESET;
        bank_mode_q = '0;
        rom_number_q = '0;
        lower_on_q = 1'b1;
        upper_on_q = 1'b1;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_map();
        test_control_words();
        test_output_stall();
        test_config_sweep();
        test_output_stall();

        wait_idle();
        repeat (8) @(negedge aclk);
        if (error_count == 0 && expected_targets.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bsmm_pkg.sv
hw/rtl/bank_switched_memory_mapper.sv
hw/rtl/bsmm_checker.sv
test/bank_switched_memory_mapper_tb.sv
